FILE: rtl/assert_macros.svh
// assertion macros used by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masks the check
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masks the check
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tlik_pkg.sv
// types, constants and helper functions for the two-link inverse kinematics block
package tlik_pkg;

  // internal cordic datapath width
  localparam int CW = 52;

  localparam logic [31:0] KGAIN = 32'h26DD3B6A;
  localparam logic signed [31:0] QONE = 32'sh4000_0000;
  localparam logic [63:0] QONE_SQ = 64'h1000_0000_0000_0000;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  localparam logic [2:0] REG_BASE_X = 3'd0;
  localparam logic [2:0] REG_BASE_Y = 3'd1;
  localparam logic [2:0] REG_UPPER = 3'd2;
  localparam logic [2:0] REG_LOWER = 3'd3;
  localparam logic [2:0] REG_BEND = 3'd4;

  typedef struct packed {
    logic signed [23:0] target_px;
    logic signed [23:0] target_py;
  } tlik_in_t;

  typedef struct packed {
    logic [15:0]        shoulder_angle;
    logic [15:0]        elbow_angle;
    logic signed [23:0] elbow_x;
    logic signed [23:0] elbow_y;
    logic signed [23:0] tip_x;
    logic signed [23:0] tip_y;
    logic               pose_updated;
  } tlik_out_t;

  typedef struct packed {
    logic start;
    logic vec;
  } tlik_cordic_req_t;

  typedef struct packed {
    logic start;
    logic sqrt_op;
  } tlik_ds_req_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_WDIR, S_M1, S_M2, S_M3, S_M4, S_CMP, S_WSQ, S_LEN,
    S_P1, S_P2, S_P3, S_P4, S_P5, S_AC, S_WDIV, S_ACSQ, S_ACSQ2, S_WSQ2,
    S_WACO, S_ANG, S_POL1, S_POL1B, S_WPOL1, S_POL2, S_POL2B, S_WPOL2,
    S_FIN, S_DONE
  } tlik_state_t;

  // arctangent of 2^-s as a 32 bit turn fraction
  function automatic logic [31:0] atan_lookup(input logic [4:0] s);
    logic [31:0] v;
    case (s)
      5'd0: v = 32'h20000000;
      5'd1: v = 32'h12E4051E;
      5'd2: v = 32'h09FB385B;
      5'd3: v = 32'h051111D4;
      5'd4: v = 32'h028B0D43;
      5'd5: v = 32'h0145D7E1;
      5'd6: v = 32'h00A2F61E;
      5'd7: v = 32'h00517C55;
      5'd8: v = 32'h0028BE53;
      5'd9: v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
    logic signed [23:0] r;
    if (v > 27'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -27'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // round half up out of 16 extra fraction bits, then undo the half-turn fold
  function automatic logic signed [24:0] cord_round(input logic signed [CW-1:0] v,
                                                    input logic flip);
    logic signed [CW-1:0] half;
    logic signed [CW-1:0] t;
    logic signed [24:0] r;
    half = CW'(32768);
    t = (v + half) >>> 16;
    r = t[24:0];
    return flip ? -r : r;
  endfunction

endpackage

FILE: rtl/two_link_inverse_kinematics.sv
// two-link planar inverse kinematics solver, top level with sequencer
//
// target channel: target_valid / target_stall with the target point in
// tlik_in_t. one target is solved at a time; target_stall stays high from the
// transfer until the sequencer is back in idle.
// pose channel: pose_valid / pose_stall with joint angles, elbow and tip
// positions and pose_updated. a finished pose sits in an output register,
// so the next target can be taken while the receiver stalls; the sequencer
// waits only when a second pose is ready before the first was taken.
// a solve in reach runs from the transfer to the pose register through five
// cordic passes, up to two divides, up to three square roots and the
// products of the shared 32x32 multiplier; the sequencer then returns to idle
// for the next target. a target beyond reach takes three cordic passes; a
// target on the base and a zero limb length in reach end with the held pose.
// configuration goes through the apb port (registers at 4*index) and is to
// be written by the user only while the block is idle; the block itself does
// not enforce this. reset returns the registers to their defaults, clears
// the held pose and empties the output register.
`include "assert_macros.svh"

module two_link_inverse_kinematics import tlik_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        target_valid,
  output logic        target_stall,
  input  tlik_in_t    target,
  output logic        pose_valid,
  input  logic        pose_stall,
  output tlik_out_t   pose,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tlik_state_t state, state_next;

  // configuration
  logic [23:0] base_x, base_y;
  logic [21:0] upper_length, lower_length;
  logic        bend_clockwise;

  // datapath registers
  logic signed [24:0] dx, dy;
  logic [49:0]        d2;
  logic [43:0]        rr, l11, l22, l12;
  logic [45:0]        ss, dd;
  logic [44:0]        l1d;
  logic [22:0]        reach_len;
  logic [31:0]        dir, ang_a, ang_b, sh, el;
  logic signed [48:0] num;
  logic [46:0]        den;
  logic               div_neg, which, upd;
  logic signed [31:0] c;
  logic signed [24:0] ux, uy, vx, vy;
  logic [63:0]        prod;

  // held pose and output register
  logic [15:0]        held_shoulder, held_elbow;
  logic signed [23:0] held_jx, held_jy, held_tx, held_ty;
  tlik_out_t          pose_r;
  logic               pose_valid_r;

  // combinational helpers
  logic [24:0]          adx, ady;
  logic [21:0]          r_len;
  logic [22:0]          sum_len;
  logic signed [48:0]   den_s;
  logic                 num_ge, num_le;
  logic [47:0]          num_mag;
  logic [31:0]          c_mag;
  logic [31:0]          ma, mb;
  logic [63:0]          mul_full;
  logic signed [29:0]   dummy_unused;
  logic signed [31:0]   cq;
  logic [31:0]          sh_rnd, el_rnd;
  logic signed [26:0]   jx, jy, tx, ty;
  logic signed [23:0]   bx_s, by_s;
  logic                 accept, out_free;
  logic                 cord_wait, ds_wait;

  tlik_cordic_req_t     cord_req;
  logic signed [CW-1:0] c_x, c_y, cord_xo, cord_yo;
  logic [31:0]          c_ang, cord_zo;
  logic                 cord_done, cord_flip;

  tlik_ds_req_t         ds_req;
  logic [63:0]          ds_a, ds_b, ds_res;
  logic                 ds_done;

  tlik_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .req  (cord_req),
    .xin  (c_x),
    .yin  (c_y),
    .ang  (c_ang),
    .done (cord_done),
    .xo   (cord_xo),
    .yo   (cord_yo),
    .zo   (cord_zo),
    .flip (cord_flip)
  );

  tlik_divsqrt u_divsqrt (
    .clk  (clk),
    .rst  (rst),
    .req  (ds_req),
    .a    (ds_a),
    .b    (ds_b),
    .done (ds_done),
    .res  (ds_res)
  );

  assign dummy_unused = '0;

  always_comb begin
    accept = target_valid && !target_stall;
    out_free = !pose_valid_r || !pose_stall;
    cord_wait = (state == S_WDIR || state == S_WACO || state == S_WPOL1 ||
                 state == S_WPOL2);
    ds_wait = (state == S_WSQ || state == S_WDIV || state == S_WSQ2);
    adx = dx[24] ? 25'(-dx) : 25'(dx);
    ady = dy[24] ? 25'(-dy) : 25'(dy);
    r_len = (upper_length > lower_length) ? (upper_length - lower_length)
                                          : (lower_length - upper_length);
    sum_len = 23'(upper_length) + 23'(lower_length);
    den_s = $signed({2'b00, den});
    num_ge = num >= den_s;
    num_le = num <= -den_s;
    num_mag = num[48] ? 48'(-num) : 48'(num);
    c_mag = c[31] ? 32'(-c) : 32'(c);
    cq = $signed({2'b00, ds_res[29:0]}) + 32'(dummy_unused);
    sh_rnd = sh + 32'h8000;
    el_rnd = el + 32'h8000;
    bx_s = $signed(base_x);
    by_s = $signed(base_y);
    jx = 27'(ux) + 27'(bx_s);
    jy = 27'(uy) + 27'(by_s);
    tx = jx + 27'(vx);
    ty = jy + 27'(vy);
    mul_full = ma * mb;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_CHECK;
      S_CHECK: state_next = (dx == '0 && dy == '0) ? S_DONE : S_WDIR;
      S_WDIR:  if (cord_done) state_next = S_M1;
      S_M1:    state_next = S_M2;
      S_M2:    state_next = S_M3;
      S_M3:    state_next = S_M4;
      S_M4:    state_next = S_CMP;
      S_CMP: begin
        if (d2 < 50'(rr)) begin
          state_next = S_LEN;
        end else if (d2 > 50'(ss)) begin
          state_next = S_POL1;
        end else begin
          state_next = S_WSQ;
        end
      end
      S_WSQ:   if (ds_done) state_next = S_LEN;
      S_LEN: begin
        state_next = (upper_length == '0 || lower_length == '0) ? S_DONE : S_P1;
      end
      S_P1:    state_next = S_P2;
      S_P2:    state_next = S_P3;
      S_P3:    state_next = S_P4;
      S_P4:    state_next = S_P5;
      S_P5:    state_next = S_AC;
      S_AC:    state_next = (num_ge || num_le) ? S_ACSQ : S_WDIV;
      S_WDIV:  if (ds_done) state_next = S_ACSQ;
      S_ACSQ:  state_next = S_ACSQ2;
      S_ACSQ2: state_next = S_WSQ2;
      S_WSQ2:  if (ds_done) state_next = S_WACO;
      S_WACO:  if (cord_done) state_next = which ? S_ANG : S_AC;
      S_ANG:   state_next = S_POL1;
      S_POL1:  state_next = S_POL1B;
      S_POL1B: state_next = S_WPOL1;
      S_WPOL1: if (cord_done) state_next = S_POL2;
      S_POL2:  state_next = S_POL2B;
      S_POL2B: state_next = S_WPOL2;
      S_WPOL2: if (cord_done) state_next = S_FIN;
      S_FIN:   state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // unit requests and operand selection
  always_comb begin
    target_stall = (state != S_IDLE);
    ma = '0;
    mb = '0;
    cord_req = '0;
    c_x = '0;
    c_y = '0;
    c_ang = '0;
    ds_req = '0;
    ds_a = '0;
    ds_b = '0;
    case (state)
      S_CHECK: begin
        cord_req.start = !(dx == '0 && dy == '0);
        cord_req.vec = 1'b1;
        c_x = CW'(dx);
        c_y = CW'(dy);
      end
      S_WDIR: begin
        ma = 32'(adx);
        mb = 32'(adx);
      end
      S_M1: begin
        ma = 32'(ady);
        mb = 32'(ady);
      end
      S_M2: begin
        ma = 32'(r_len);
        mb = 32'(r_len);
      end
      S_M3: begin
        ma = 32'(sum_len);
        mb = 32'(sum_len);
      end
      S_CMP: begin
        ds_req.start = !(d2 < 50'(rr)) && !(d2 > 50'(ss));
        ds_req.sqrt_op = 1'b1;
        ds_a = 64'(d2);
      end
      S_LEN: begin
        ma = 32'(reach_len);
        mb = 32'(reach_len);
      end
      S_P1: begin
        ma = 32'(upper_length);
        mb = 32'(upper_length);
      end
      S_P2: begin
        ma = 32'(lower_length);
        mb = 32'(lower_length);
      end
      S_P3: begin
        ma = 32'(upper_length);
        mb = 32'(lower_length);
      end
      S_P4: begin
        ma = 32'(upper_length);
        mb = 32'(reach_len);
      end
      S_AC: begin
        ds_req.start = !(num_ge || num_le);
        ds_req.sqrt_op = 1'b0;
        ds_a = 64'(num_mag);
        ds_b = 64'(den);
      end
      S_ACSQ: begin
        ma = c_mag;
        mb = c_mag;
      end
      S_ACSQ2: begin
        // sine of the arc cosine
        ds_req.start = 1'b1;
        ds_req.sqrt_op = 1'b1;
        ds_a = QONE_SQ - prod;
      end
      S_WSQ2: begin
        cord_req.start = ds_done;
        cord_req.vec = 1'b1;
        c_x = CW'(c);
        c_y = CW'($signed({1'b0, ds_res[31:0]}));
      end
      S_POL1: begin
        ma = 32'(upper_length);
        mb = KGAIN;
      end
      S_POL1B: begin
        cord_req.start = 1'b1;
        c_x = $signed(CW'(prod[51:14]));
        c_ang = sh;
      end
      S_POL2: begin
        ma = 32'(lower_length);
        mb = KGAIN;
      end
      S_POL2B: begin
        cord_req.start = 1'b1;
        c_x = $signed(CW'(prod[51:14]));
        c_ang = sh + el;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= mul_full;
    case (state)
      S_IDLE: begin
        if (accept) begin
          dx <= 25'(target.target_px) - 25'(bx_s);
          dy <= 25'(target.target_py) - 25'(by_s);
        end
      end
      S_CHECK: upd <= 1'b0;
      S_WDIR:  if (cord_done) dir <= cord_zo;
      S_M1:    d2 <= prod[49:0];
      S_M2:    d2 <= d2 + prod[49:0];
      S_M3:    rr <= prod[43:0];
      S_M4:    ss <= prod[45:0];
      S_CMP: begin
        if (d2 < 50'(rr)) begin
          // too close: push out to the inner radius
          reach_len <= 23'(r_len);
        end else if (d2 > 50'(ss)) begin
          // beyond reach: stretch straight
          sh <= dir;
          el <= '0;
        end
      end
      S_WSQ:   if (ds_done) reach_len <= ds_res[22:0];
      S_P1:    dd <= prod[45:0];
      S_P2:    l11 <= prod[43:0];
      S_P3:    l22 <= prod[43:0];
      S_P4:    l12 <= prod[43:0];
      S_P5: begin
        l1d <= prod[44:0];
        num <= 49'(l11) + 49'(l22) - 49'(dd);
        den <= 47'({l12, 1'b0});
        which <= 1'b0;
      end
      S_AC: begin
        if (num_ge) begin
          c <= QONE;
        end else if (num_le) begin
          c <= -QONE;
        end
        div_neg <= num[48];
      end
      S_WDIV:  if (ds_done) c <= div_neg ? -cq : cq;
      S_WACO: begin
        if (cord_done) begin
          if (!which) begin
            ang_b <= cord_zo;
            num <= 49'(l11) + 49'(dd) - 49'(l22);
            den <= 47'({l1d, 1'b0});
            which <= 1'b1;
          end else begin
            ang_a <= cord_zo;
          end
        end
      end
      S_ANG: begin
        if (bend_clockwise) begin
          sh <= dir + ang_a;
          el <= HALF_TURN + ang_b;
        end else begin
          sh <= dir - ang_a;
          el <= HALF_TURN - ang_b;
        end
      end
      S_WPOL1: begin
        if (cord_done) begin
          ux <= cord_round(cord_xo, cord_flip);
          uy <= cord_round(cord_yo, cord_flip);
        end
      end
      S_WPOL2: begin
        if (cord_done) begin
          vx <= cord_round(cord_xo, cord_flip);
          vy <= cord_round(cord_yo, cord_flip);
        end
      end
      S_FIN:   upd <= 1'b1;
      default: begin
      end
    endcase
  end

  // held pose
  always_ff @(posedge clk) begin
    if (rst) begin
      held_shoulder <= '0;
      held_elbow <= '0;
      held_jx <= '0;
      held_jy <= '0;
      held_tx <= '0;
      held_ty <= '0;
    end else if (state == S_FIN) begin
      held_shoulder <= sh_rnd[31:16];
      held_elbow <= el_rnd[31:16];
      held_jx <= sat24(jx);
      held_jy <= sat24(jy);
      held_tx <= sat24(tx);
      held_ty <= sat24(ty);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pose_valid_r <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      pose_valid_r <= 1'b1;
      pose_r.shoulder_angle <= held_shoulder;
      pose_r.elbow_angle <= held_elbow;
      pose_r.elbow_x <= held_jx;
      pose_r.elbow_y <= held_jy;
      pose_r.tip_x <= held_tx;
      pose_r.tip_y <= held_ty;
      pose_r.pose_updated <= upd;
    end else if (pose_valid_r && !pose_stall) begin
      pose_valid_r <= 1'b0;
    end
  end

  assign pose_valid = pose_valid_r;
  assign pose = pose_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_x <= '0;
      base_y <= '0;
      upper_length <= 22'd256;
      lower_length <= 22'd256;
      bend_clockwise <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_BASE_X: base_x <= pwdata[23:0];
        REG_BASE_Y: base_y <= pwdata[23:0];
        REG_UPPER:  upper_length <= pwdata[21:0];
        REG_LOWER:  lower_length <= pwdata[21:0];
        REG_BEND:   bend_clockwise <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    pready = 1'b1;
    case (paddr[4:2])
      REG_BASE_X: prdata = 32'(base_x);
      REG_BASE_Y: prdata = 32'(base_y);
      REG_UPPER:  prdata = 32'(upper_length);
      REG_LOWER:  prdata = 32'(lower_length);
      REG_BEND:   prdata = 32'(bend_clockwise);
      default:    prdata = '0;
    endcase
  end

  `ASSERT_NEXT(a_accept_starts, clk, rst, accept, state == S_CHECK, "transfer did not start a solve")
  `ASSERT_IMPL(a_cordic_done_wait, clk, rst, cord_done, cord_wait, "cordic done outside a wait")
  `ASSERT_IMPL(a_ds_done_wait, clk, rst, ds_done, ds_wait, "divide or root done outside a wait")

endmodule

FILE: rtl/tlik_cordic.sv
// shared cordic unit, vectoring or rotation, one micro-rotation per cycle
module tlik_cordic import tlik_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tlik_cordic_req_t     req,
  input  logic signed [CW-1:0] xin,
  input  logic signed [CW-1:0] yin,
  input  logic [31:0]          ang,
  output logic                 done,
  output logic signed [CW-1:0] xo,
  output logic signed [CW-1:0] yo,
  output logic [31:0]          zo,
  output logic                 flip
);

  localparam int CNT_W = $clog2(STEPS + 1);
  localparam logic signed [33:0] QTR = 34'sh0_4000_0000;
  localparam logic signed [33:0] HALF = 34'sh0_8000_0000;

  logic signed [CW-1:0] x, y;
  logic signed [33:0]   z;
  logic [CNT_W-1:0]     cnt;
  logic                 busy, vec_r, flip_r;

  logic [4:0]           sh;
  logic signed [CW-1:0] xs, ys, xp, yp;
  logic signed [33:0]   at, zs;
  logic                 dsel;

  always_comb begin
    sh = 5'(cnt);
    xs = x >>> sh;
    ys = y >>> sh;
    at = $signed({2'b00, atan_lookup(sh)});
    // vectoring drives y to zero, rotation drives z to zero
    dsel = vec_r ? ~y[CW-1] : z[33];
    xp = xin <<< 16;
    yp = yin <<< 16;
    zs = $signed({{2{ang[31]}}, ang});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= '0;
        vec_r <= req.vec;
        if (req.vec) begin
          flip_r <= 1'b0;
          if (xin[CW-1]) begin
            x <= -xp;
            y <= -yp;
            z <= HALF;
          end else begin
            x <= xp;
            y <= yp;
            z <= '0;
          end
        end else begin
          x <= xin;
          y <= '0;
          if (zs > QTR) begin
            z <= zs - HALF;
            flip_r <= 1'b1;
          end else if (zs < -QTR) begin
            z <= zs + HALF;
            flip_r <= 1'b1;
          end else begin
            z <= zs;
            flip_r <= 1'b0;
          end
        end
      end else if (busy) begin
        if (dsel) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign xo = x;
  assign yo = y;
  assign zo = z[31:0];
  assign flip = flip_r;

endmodule

FILE: rtl/tlik_divsqrt.sv
// shared shift-subtract unit: restoring fraction divide or integer square root
module tlik_divsqrt import tlik_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  tlik_ds_req_t req,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [63:0]  res
);

  logic [63:0] acc, den, bitv, res_r;
  logic [5:0]  cnt;
  logic        busy, op;

  logic [63:0] cmp_a, cmp_b;
  logic [64:0] diff;
  logic        ge;

  always_comb begin
    cmp_a = op ? acc : {acc[62:0], 1'b0};
    cmp_b = op ? (res_r + bitv) : den;
    diff = {1'b0, cmp_a} - {1'b0, cmp_b};
    ge = ~diff[64];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op <= req.sqrt_op;
        acc <= a;
        den <= b;
        res_r <= '0;
        bitv <= 64'h4000_0000_0000_0000;
        cnt <= '0;
      end else if (busy) begin
        if (op) begin
          if (ge) begin
            acc <= diff[63:0];
            res_r <= (res_r >> 1) + bitv;
          end else begin
            res_r <= res_r >> 1;
          end
          bitv <= bitv >> 2;
        end else begin
          acc <= ge ? diff[63:0] : cmp_a;
          res_r <= {res_r[62:0], ge};
        end
        cnt <= cnt + 1'b1;
        // 32 root steps, 30 quotient bits
        if ((op && cnt == 6'd31) || (!op && cnt == 6'd29)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res = res_r;

endmodule
